// ----- src/rb2d_pkg.sv -----
package rb2d_pkg;

  localparam int unsigned Q_FRAC      = 16;
  localparam int unsigned SQRT_STEPS  = 32;
  localparam int unsigned FDIV_STEPS  = 17;
  localparam int unsigned CDIV_STEPS  = 31;

  // speed below 0.01 (655 in Q16.16), compared squared
  localparam logic [63:0] STATIC_SQ   = 64'd429025;
  localparam logic [16:0] DAMP_ONE    = 17'd65536;

  typedef enum logic [2:0] {
    REG_GRAVITY      = 3'd0,
    REG_TIME_STEP    = 3'd1,
    REG_BODY_MASS    = 3'd2,
    REG_INV_MASS     = 3'd3,
    REG_GRAV_SCALE   = 3'd4,
    REG_KIN_FRICTION = 3'd5,
    REG_LIN_DAMPING  = 3'd6,
    REG_MAX_SPEED    = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic               vld;
    logic [15:0]        tag;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               grounded;
    logic               stop;
  } item_t;

  function automatic logic signed [32:0] sx33(input logic signed [31:0] v);
    return {v[31], v};
  endfunction

  function automatic logic signed [31:0] sat50(input logic signed [49:0] v);
    if (v > 50'sd2147483647) return 32'sh7fffffff;
    if (v < -50'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // q16.16 product, floor shift, saturated
  function automatic logic signed [31:0] qmul(input logic signed [32:0] a,
                                               input logic signed [32:0] b);
    logic signed [65:0] p;
    p = a * b;
    return sat50($signed(p[65:Q_FRAC]));
  endfunction

  function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [32:0] s;
    s = sx33(a) + sx33(b);
    if (s > 33'sd2147483647) return 32'sh7fffffff;
    if (s < -33'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  function automatic logic [31:0] mag(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic item_t with_vel(input item_t it, input logic signed [31:0] vx,
                                     input logic signed [31:0] vy);
    item_t r;
    r = it;
    r.vx = vx;
    r.vy = vy;
    return r;
  endfunction

  function automatic item_t with_pos(input item_t it, input logic signed [31:0] px,
                                     input logic signed [31:0] py);
    item_t r;
    r = it;
    r.px = px;
    r.py = py;
    return r;
  endfunction

  function automatic item_t with_stop(input item_t it, input logic stop);
    item_t r;
    r = it;
    r.stop = stop;
    return r;
  endfunction

endpackage

// ----- src/rigid_body_2d_step_top.sv -----
// channel  direction  contents
// in_      slave      tdata: body_tag, pos_x/y, vel_x/y, acc_x/y, impulse_x/y, force_x/y
//                     tuser: grounded
// out_     master     tdata: out_tag, new_pos_x/y, new_vel_x/y
// cfg_     write      cfg_index selects one of eight material registers
//
// one body per cycle unless out is stalled; from acceptance to out_tvalid each request passes
// through two 32-step square root pipelines and two divider pipelines (17 and 31 steps)
// synchronous active-low reset clears valid bits and restores the register defaults
// a held result freezes the whole pipeline; in_tready falls only while out is stalled
module rigid_body_2d_step_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // body_tag, pos_x, pos_y, vel_x, vel_y, acc_x, acc_y, impulse_x, impulse_y, force_x, force_y
  input  logic [335:0] in_tdata,
  // grounded
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_tag, new_pos_x, new_pos_y, new_vel_x, new_vel_y
  output logic [143:0] out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);

  localparam int unsigned SQN = rb2d_pkg::SQRT_STEPS;
  localparam int unsigned FDN = rb2d_pkg::FDIV_STEPS;
  localparam int unsigned CDN = rb2d_pkg::CDIV_STEPS;

  // configuration
  logic signed [31:0] grav_r, gsc_r;
  logic [30:0]        dt_r, mass_r, im_r, kf_r, max_r;
  logic [16:0]        damp_r;
  logic signed [31:0] gs_r, gterm_r, kfm_r, fr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r <= '0;
      dt_r   <= 31'd1092;
      mass_r <= 31'd65536;
      im_r   <= 31'd65536;
      gsc_r  <= 32'sd65536;
      kf_r   <= '0;
      damp_r <= '0;
      max_r  <= 31'h7fffffff;
    end else if (cfg_we) begin
      unique case (rb2d_pkg::cfg_reg_t'(cfg_index))
        rb2d_pkg::REG_GRAVITY:      grav_r <= cfg_wdata;
        rb2d_pkg::REG_TIME_STEP:    dt_r   <= cfg_wdata[30:0];
        rb2d_pkg::REG_BODY_MASS:    mass_r <= cfg_wdata[30:0];
        rb2d_pkg::REG_INV_MASS:     im_r   <= cfg_wdata[30:0];
        rb2d_pkg::REG_GRAV_SCALE:   gsc_r  <= cfg_wdata;
        rb2d_pkg::REG_KIN_FRICTION: kf_r   <= cfg_wdata[30:0];
        rb2d_pkg::REG_LIN_DAMPING:  damp_r <= cfg_wdata[16:0];
        rb2d_pkg::REG_MAX_SPEED:    max_r  <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  logic signed [32:0] dt_s, mass_s, im_s, kf_s, grav_s, gsc_s;
  logic               mov;
  logic [16:0]        keep;

  assign dt_s   = $signed({2'b00, dt_r});
  assign mass_s = $signed({2'b00, mass_r});
  assign im_s   = $signed({2'b00, im_r});
  assign kf_s   = $signed({2'b00, kf_r});
  assign grav_s = rb2d_pkg::sx33(grav_r);
  assign gsc_s  = rb2d_pkg::sx33(gsc_r);
  assign mov    = (im_r != '0);
  assign keep   = rb2d_pkg::DAMP_ONE -
                  ((damp_r > rb2d_pkg::DAMP_ONE) ? rb2d_pkg::DAMP_ONE : damp_r);

  // material products, registered; gterm_r and fr_r are built from gs_r and kfm_r
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gs_r    <= '0;
      gterm_r <= '0;
      kfm_r   <= '0;
      fr_r    <= '0;
    end else begin
      gs_r    <= rb2d_pkg::qmul(grav_s, gsc_s);
      gterm_r <= rb2d_pkg::qmul(rb2d_pkg::sx33(gs_r), mass_s);
      kfm_r   <= rb2d_pkg::qmul(kf_s, mass_s);
      fr_r    <= rb2d_pkg::qmul(rb2d_pkg::sx33(kfm_r), grav_s);
    end
  end

  logic          adv;
  rb2d_pkg::item_t out_it_r;

  assign adv       = !out_it_r.vld || out_tready;
  assign in_tready = adv;

  // early stages: acceleration, impulse, force
  rb2d_pkg::item_t    in_it;
  rb2d_pkg::item_t    e1_r, e2_r, e3_r, e4_r, e5_r, e6_r, e7_r;
  logic signed [31:0] e1_max_r, e1_may_r, e1_mix_r, e1_miy_r, e1_fx_r, e1_fy_r;
  logic signed [31:0] e2_mix_r, e2_miy_r, e2_fx_r, e2_fy_r;
  logic signed [31:0] e3_fx_r, e3_fy_r, e4_mfx_r, e4_mfy_r, e5_mfx_r, e5_mfy_r;
  logic [63:0]        e7_sqx_r, e7_sqy_r;

  always_comb begin
    in_it          = '0;
    in_it.vld      = in_tvalid;
    in_it.tag      = in_tdata[15:0];
    in_it.px       = in_tdata[47:16];
    in_it.py       = in_tdata[79:48];
    in_it.vx       = in_tdata[111:80];
    in_it.vy       = in_tdata[143:112];
    in_it.grounded = in_tuser[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_r <= '0;
      e2_r <= '0;
      e3_r <= '0;
      e4_r <= '0;
      e5_r <= '0;
      e6_r <= '0;
      e7_r <= '0;
    end else if (adv) begin
      e1_r     <= in_it;
      e1_max_r <= rb2d_pkg::qmul(rb2d_pkg::sx33(in_tdata[175:144]), dt_s);
      e1_may_r <= rb2d_pkg::qmul(rb2d_pkg::sx33(in_tdata[207:176]), dt_s);
      e1_mix_r <= rb2d_pkg::qmul(rb2d_pkg::sx33(in_tdata[239:208]), im_s);
      e1_miy_r <= rb2d_pkg::qmul(rb2d_pkg::sx33(in_tdata[271:240]), im_s);
      e1_fx_r  <= in_tdata[303:272];
      e1_fy_r  <= in_tdata[335:304];

      e2_r <= mov ? rb2d_pkg::with_vel(e1_r, rb2d_pkg::qadd(e1_r.vx, e1_max_r),
                                       rb2d_pkg::qadd(e1_r.vy, e1_may_r)) : e1_r;
      e2_mix_r <= e1_mix_r;
      e2_miy_r <= e1_miy_r;
      e2_fx_r  <= e1_fx_r;
      e2_fy_r  <= e1_fy_r;

      e3_r <= mov ? rb2d_pkg::with_vel(e2_r, rb2d_pkg::qadd(e2_r.vx, e2_mix_r),
                                       rb2d_pkg::qadd(e2_r.vy, e2_miy_r)) : e2_r;
      e3_fx_r <= e2_fx_r;
      // gravity joins the force only while airborne
      e3_fy_r <= (mov && !e2_r.grounded) ? rb2d_pkg::qadd(e2_fy_r, gterm_r) : e2_fy_r;

      e4_r     <= e3_r;
      e4_mfx_r <= rb2d_pkg::qmul(rb2d_pkg::sx33(e3_fx_r), im_s);
      e4_mfy_r <= rb2d_pkg::qmul(rb2d_pkg::sx33(e3_fy_r), im_s);

      e5_r     <= e4_r;
      e5_mfx_r <= rb2d_pkg::qmul(rb2d_pkg::sx33(e4_mfx_r), dt_s);
      e5_mfy_r <= rb2d_pkg::qmul(rb2d_pkg::sx33(e4_mfy_r), dt_s);

      e6_r <= mov ? rb2d_pkg::with_vel(e5_r, rb2d_pkg::qadd(e5_r.vx, e5_mfx_r),
                                       rb2d_pkg::qadd(e5_r.vy, e5_mfy_r)) : e5_r;

      e7_r     <= e6_r;
      e7_sqx_r <= 64'(rb2d_pkg::mag(e6_r.vx)) * 64'(rb2d_pkg::mag(e6_r.vx));
      e7_sqy_r <= 64'(rb2d_pkg::mag(e6_r.vy)) * 64'(rb2d_pkg::mag(e6_r.vy));
    end
  end

  // friction speed: square root, one result bit per stage
  rb2d_pkg::item_t s1_it_r   [0:SQN];
  logic [63:0]     s1_rem_r  [0:SQN];
  logic [63:0]     s1_root_r [0:SQN];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_it_r[0] <= '0;
    end else if (adv) begin
      s1_it_r[0]   <= rb2d_pkg::with_stop(e7_r, e7_r.grounded &&
                        ((e7_sqx_r + e7_sqy_r) < rb2d_pkg::STATIC_SQ));
      s1_rem_r[0]  <= e7_sqx_r + e7_sqy_r;
      s1_root_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQN; k++) begin : g_sqrt1
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    assign trial = s1_root_r[k] + BIT;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s1_it_r[k+1] <= '0;
      end else if (adv) begin
        s1_it_r[k+1] <= s1_it_r[k];
        if (s1_rem_r[k] >= trial) begin
          s1_rem_r[k+1]  <= s1_rem_r[k] - trial;
          s1_root_r[k+1] <= (s1_root_r[k] >> 1) + BIT;
        end else begin
          s1_rem_r[k+1]  <= s1_rem_r[k];
          s1_root_r[k+1] <= s1_root_r[k] >> 1;
        end
      end
    end
  end

  // friction direction: |v| * 1.0 / speed, restoring divider
  rb2d_pkg::item_t fd_it_r  [0:FDN];
  logic [31:0]     fd_d_r   [0:FDN];
  logic [47:0]     fd_remx_r[0:FDN];
  logic [47:0]     fd_remy_r[0:FDN];
  logic [16:0]     fd_qx_r  [0:FDN];
  logic [16:0]     fd_qy_r  [0:FDN];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fd_it_r[0] <= '0;
    end else if (adv) begin
      fd_it_r[0]   <= s1_it_r[SQN];
      fd_d_r[0]    <= s1_root_r[SQN][31:0];
      fd_remx_r[0] <= {rb2d_pkg::mag(s1_it_r[SQN].vx), 16'h0};
      fd_remy_r[0] <= {rb2d_pkg::mag(s1_it_r[SQN].vy), 16'h0};
      fd_qx_r[0]   <= '0;
      fd_qy_r[0]   <= '0;
    end
  end

  for (genvar j = 0; j < FDN; j++) begin : g_fdiv
    localparam int unsigned SH = FDN - 1 - j;
    logic [48:0] dsh;
    logic        bx, by;
    assign dsh = 49'(fd_d_r[j]) << SH;
    assign bx  = ({1'b0, fd_remx_r[j]} >= dsh);
    assign by  = ({1'b0, fd_remy_r[j]} >= dsh);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        fd_it_r[j+1] <= '0;
      end else if (adv) begin
        fd_it_r[j+1]   <= fd_it_r[j];
        fd_d_r[j+1]    <= fd_d_r[j];
        fd_remx_r[j+1] <= bx ? fd_remx_r[j] - dsh[47:0] : fd_remx_r[j];
        fd_remy_r[j+1] <= by ? fd_remy_r[j] - dsh[47:0] : fd_remy_r[j];
        fd_qx_r[j+1]   <= {fd_qx_r[j][15:0], bx};
        fd_qy_r[j+1]   <= {fd_qy_r[j][15:0], by};
      end
    end
  end

  // friction force into velocity, then damping
  rb2d_pkg::item_t    f1_r, f2_r, f3_r, f4_r, dm_r;
  logic signed [32:0] dirx, diry;
  logic signed [31:0] f1_tx_r, f1_ty_r, f2_tx_r, f2_ty_r, f3_tx_r, f3_ty_r;

  // direction opposes motion, truncated toward zero
  assign dirx = (!fd_it_r[FDN].vx[31] && fd_it_r[FDN].vx != '0) ?
                33'sd0 - $signed({16'h0, fd_qx_r[FDN]}) : $signed({16'h0, fd_qx_r[FDN]});
  assign diry = (!fd_it_r[FDN].vy[31] && fd_it_r[FDN].vy != '0) ?
                33'sd0 - $signed({16'h0, fd_qy_r[FDN]}) : $signed({16'h0, fd_qy_r[FDN]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_r <= '0;
      f2_r <= '0;
      f3_r <= '0;
      f4_r <= '0;
      dm_r <= '0;
    end else if (adv) begin
      f1_r    <= fd_it_r[FDN];
      f1_tx_r <= rb2d_pkg::qmul(dirx, rb2d_pkg::sx33(fr_r));
      f1_ty_r <= rb2d_pkg::qmul(diry, rb2d_pkg::sx33(fr_r));

      f2_r    <= f1_r;
      f2_tx_r <= rb2d_pkg::qmul(rb2d_pkg::sx33(f1_tx_r), im_s);
      f2_ty_r <= rb2d_pkg::qmul(rb2d_pkg::sx33(f1_ty_r), im_s);

      f3_r    <= f2_r;
      f3_tx_r <= rb2d_pkg::qmul(rb2d_pkg::sx33(f2_tx_r), dt_s);
      f3_ty_r <= rb2d_pkg::qmul(rb2d_pkg::sx33(f2_ty_r), dt_s);

      f4_r <= !f3_r.grounded ? f3_r :
              f3_r.stop ? rb2d_pkg::with_vel(f3_r, '0, '0) :
              rb2d_pkg::with_vel(f3_r, rb2d_pkg::qadd(f3_r.vx, f3_tx_r),
                                 rb2d_pkg::qadd(f3_r.vy, f3_ty_r));

      dm_r <= rb2d_pkg::with_vel(f4_r,
                rb2d_pkg::qmul(rb2d_pkg::sx33(f4_r.vx), $signed({16'h0, keep})),
                rb2d_pkg::qmul(rb2d_pkg::sx33(f4_r.vy), $signed({16'h0, keep})));
    end
  end

  // speed limit: squares, square root
  rb2d_pkg::item_t q1_r;
  logic [63:0]     q1_sqx_r, q1_sqy_r;
  rb2d_pkg::item_t s2_it_r   [0:SQN];
  logic [63:0]     s2_rem_r  [0:SQN];
  logic [63:0]     s2_root_r [0:SQN];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q1_r       <= '0;
      s2_it_r[0] <= '0;
    end else if (adv) begin
      q1_r         <= dm_r;
      q1_sqx_r     <= 64'(rb2d_pkg::mag(dm_r.vx)) * 64'(rb2d_pkg::mag(dm_r.vx));
      q1_sqy_r     <= 64'(rb2d_pkg::mag(dm_r.vy)) * 64'(rb2d_pkg::mag(dm_r.vy));
      s2_it_r[0]   <= q1_r;
      s2_rem_r[0]  <= q1_sqx_r + q1_sqy_r;
      s2_root_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQN; k++) begin : g_sqrt2
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    assign trial = s2_root_r[k] + BIT;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s2_it_r[k+1] <= '0;
      end else if (adv) begin
        s2_it_r[k+1] <= s2_it_r[k];
        if (s2_rem_r[k] >= trial) begin
          s2_rem_r[k+1]  <= s2_rem_r[k] - trial;
          s2_root_r[k+1] <= (s2_root_r[k] >> 1) + BIT;
        end else begin
          s2_rem_r[k+1]  <= s2_rem_r[k];
          s2_root_r[k+1] <= s2_root_r[k] >> 1;
        end
      end
    end
  end

  // clamp: |v| * max_speed / speed, only used when speed exceeds the limit
  rb2d_pkg::item_t cd_it_r  [0:CDN];
  logic            cd_need_r[0:CDN];
  logic [31:0]     cd_d_r   [0:CDN];
  logic [62:0]     cd_remx_r[0:CDN];
  logic [62:0]     cd_remy_r[0:CDN];
  logic [30:0]     cd_qx_r  [0:CDN];
  logic [30:0]     cd_qy_r  [0:CDN];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd_it_r[0] <= '0;
    end else if (adv) begin
      cd_it_r[0]   <= s2_it_r[SQN];
      cd_need_r[0] <= (s2_root_r[SQN][31:0] > {1'b0, max_r});
      cd_d_r[0]    <= s2_root_r[SQN][31:0];
      cd_remx_r[0] <= 63'(rb2d_pkg::mag(s2_it_r[SQN].vx)) * 63'(max_r);
      cd_remy_r[0] <= 63'(rb2d_pkg::mag(s2_it_r[SQN].vy)) * 63'(max_r);
      cd_qx_r[0]   <= '0;
      cd_qy_r[0]   <= '0;
    end
  end

  for (genvar j = 0; j < CDN; j++) begin : g_cdiv
    localparam int unsigned SH = CDN - 1 - j;
    logic [63:0] dsh;
    logic        bx, by;
    assign dsh = 64'(cd_d_r[j]) << SH;
    assign bx  = ({1'b0, cd_remx_r[j]} >= dsh);
    assign by  = ({1'b0, cd_remy_r[j]} >= dsh);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cd_it_r[j+1] <= '0;
      end else if (adv) begin
        cd_it_r[j+1]   <= cd_it_r[j];
        cd_need_r[j+1] <= cd_need_r[j];
        cd_d_r[j+1]    <= cd_d_r[j];
        cd_remx_r[j+1] <= bx ? cd_remx_r[j] - dsh[62:0] : cd_remx_r[j];
        cd_remy_r[j+1] <= by ? cd_remy_r[j] - dsh[62:0] : cd_remy_r[j];
        cd_qx_r[j+1]   <= {cd_qx_r[j][29:0], bx};
        cd_qy_r[j+1]   <= {cd_qy_r[j][29:0], by};
      end
    end
  end

  // final velocity and position
  rb2d_pkg::item_t    cl_r, p1_r;
  logic signed [31:0] p1_mpx_r, p1_mpy_r;
  logic signed [31:0] cqx, cqy;

  assign cqx = $signed({1'b0, cd_qx_r[CDN]});
  assign cqy = $signed({1'b0, cd_qy_r[CDN]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cl_r     <= '0;
      p1_r     <= '0;
      out_it_r <= '0;
    end else if (adv) begin
      cl_r <= cd_need_r[CDN] ?
              rb2d_pkg::with_vel(cd_it_r[CDN], cd_it_r[CDN].vx[31] ? 32'sd0 - cqx : cqx,
                                 cd_it_r[CDN].vy[31] ? 32'sd0 - cqy : cqy) :
              cd_it_r[CDN];

      p1_r     <= cl_r;
      p1_mpx_r <= rb2d_pkg::qmul(rb2d_pkg::sx33(cl_r.vx), dt_s);
      p1_mpy_r <= rb2d_pkg::qmul(rb2d_pkg::sx33(cl_r.vy), dt_s);

      out_it_r <= rb2d_pkg::with_pos(p1_r, rb2d_pkg::qadd(p1_r.px, p1_mpx_r),
                                     rb2d_pkg::qadd(p1_r.py, p1_mpy_r));
    end
  end

  assign out_tvalid = out_it_r.vld;
  assign out_tdata  = {out_it_r.vy, out_it_r.vx, out_it_r.py, out_it_r.px, out_it_r.tag};

`ifndef ASSERT_OFF
  // a body slower than the static limit on ground leaves friction at rest
  a_static_stop: assert property (@(posedge clk) disable iff (!rst_n)
    adv && f3_r.vld && f3_r.stop |=> f4_r.vx == '0 && f4_r.vy == '0)
    else $error("static stop did not zero velocity");

  // airborne bodies pass the friction stage untouched
  a_air_no_fric: assert property (@(posedge clk) disable iff (!rst_n)
    adv && f3_r.vld && !f3_r.grounded |=> f4_r.vx == $past(f3_r.vx) &&
                                           f4_r.vy == $past(f3_r.vy))
    else $error("friction applied to airborne body");

  // after clamping no component exceeds the speed limit
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    cl_r.vld |-> rb2d_pkg::mag(cl_r.vx) <= {1'b0, max_r} &&
                 rb2d_pkg::mag(cl_r.vy) <= {1'b0, max_r})
    else $error("velocity above max_speed after clamp");
`endif

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;

  localparam longint MAX32 = 64'sd2147483647;
  localparam longint MIN32 = -64'sd2147483648;
  localparam int unsigned PIPE_DEPTH = 132;
  localparam longint CYCLE_LIMIT = 1500000;

  typedef struct {
    logic [15:0] tag;
    longint      px, py, vx, vy;
  } body_state_t;

  typedef struct {
    logic [15:0] tag;
    longint      px, py, vx, vy, ax, ay, ix, iy, fx, fy;
    logic        grounded;
  } body_req_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [335:0] in_tdata;
  logic [0:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [143:0] out_tdata;
  logic         cfg_we;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_wdata;

  rigid_body_2d_step_top dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .cfg_we, .cfg_index, .cfg_wdata
  );

  // material registers as the block should hold them
  longint exp_gravity, m_dt, m_mass, m_inv_mass, m_gscale, m_mu, m_damping, m_max_speed;

  body_state_t expected_bodies[$];
  int          failures;
  longint      cycle_count;
  bit          stall_free;
  int          hold_cnt;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint sat32(longint v);
    if (v > MAX32) return MAX32;
    if (v < MIN32) return MIN32;
    return v;
  endfunction

  // floor of the 64-bit product shifted by 16, saturated to 32 bits
  function automatic longint fxmul(longint a, longint b);
    longint p;
    p = a * b;
    return sat32(p >>> 16);
  endfunction

  function automatic longint fxadd(longint a, longint b);
    return sat32(a + b);
  endfunction

  function automatic longint unsigned isqrt(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned speed_sq(longint x, longint y);
    longint unsigned ax, ay;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    return ax * ax + ay * ay;
  endfunction

  function automatic body_state_t step_body(body_req_t r);
    body_state_t o;
    longint vx, vy, fy, fr, sp, dx, dy, keep;
    longint unsigned s2, spd;
    vx = r.vx;
    vy = r.vy;
    fy = r.fy;
    if (m_inv_mass != 0) begin
      vx = fxadd(vx, fxmul(r.ax, m_dt));
      vy = fxadd(vy, fxmul(r.ay, m_dt));
      if (!r.grounded) fy = fxadd(fy, fxmul(fxmul(exp_gravity, m_gscale), m_mass));
      vx = fxadd(vx, fxmul(r.ix, m_inv_mass));
      vy = fxadd(vy, fxmul(r.iy, m_inv_mass));
      vx = fxadd(vx, fxmul(fxmul(r.fx, m_inv_mass), m_dt));
      vy = fxadd(vy, fxmul(fxmul(fy, m_inv_mass), m_dt));
    end
    if (r.grounded) begin
      s2 = speed_sq(vx, vy);
      if (s2 < 64'd429025) begin
        vx = 0;
        vy = 0;
      end else begin
        fr = fxmul(fxmul(m_mu, m_mass), exp_gravity);
        sp = longint'(isqrt(s2));
        dx = -(vx * 65536) / sp;
        dy = -(vy * 65536) / sp;
        vx = fxadd(vx, fxmul(fxmul(fxmul(dx, fr), m_inv_mass), m_dt));
        vy = fxadd(vy, fxmul(fxmul(fxmul(dy, fr), m_inv_mass), m_dt));
      end
    end
    keep = 65536 - (m_damping > 65536 ? 65536 : m_damping);
    vx = fxmul(vx, keep);
    vy = fxmul(vy, keep);
    spd = isqrt(speed_sq(vx, vy));
    if (longint'(spd) > m_max_speed) begin
      vx = (vx * m_max_speed) / longint'(spd);
      vy = (vy * m_max_speed) / longint'(spd);
    end
    o.tag = r.tag;
    o.px = fxadd(r.px, fxmul(vx, m_dt));
    o.py = fxadd(r.py, fxmul(vy, m_dt));
    o.vx = vx;
    o.vy = vy;
    return o;
  endfunction

  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (stall_free || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic longint rand_s32();
    int roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0: return MAX32;
      1: return MIN32;
      2: return 0;
      3, 4: return longint'($signed(32'($urandom_range(0, 2000000)))) - 1000000;
      default: return longint'($signed($urandom()));
    endcase
  endfunction

  // in_tvalid stays high after a request until a gap or an idle period lowers it
  task automatic send_body(body_req_t r);
    int gap;
    gap = gap_len();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {r.fy[31:0], r.fx[31:0], r.iy[31:0], r.ix[31:0], r.ay[31:0], r.ax[31:0],
                  r.vy[31:0], r.vx[31:0], r.py[31:0], r.px[31:0], r.tag};
    in_tuser  <= r.grounded;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_bodies.push_back(step_body(r));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_bodies.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
  endtask

  task automatic write_reg(rb2d_pkg::cfg_reg_t idx, longint value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[31:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rb2d_pkg::REG_GRAVITY:      exp_gravity = longint'($signed(value[31:0]));
      rb2d_pkg::REG_TIME_STEP:    m_dt        = value & 64'h7fffffff;
      rb2d_pkg::REG_BODY_MASS:    m_mass      = value & 64'h7fffffff;
      rb2d_pkg::REG_INV_MASS:     m_inv_mass  = value & 64'h7fffffff;
      rb2d_pkg::REG_GRAV_SCALE:   m_gscale    = longint'($signed(value[31:0]));
      rb2d_pkg::REG_KIN_FRICTION: m_mu        = value & 64'h7fffffff;
      rb2d_pkg::REG_LIN_DAMPING:  m_damping   = value & 64'h1ffff;
      rb2d_pkg::REG_MAX_SPEED:    m_max_speed = value & 64'h7fffffff;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic body_req_t rand_body(bit plausible);
    body_req_t r;
    r.tag = 16'($urandom());
    r.grounded = $urandom_range(0, 1);
    if (plausible) begin
      // moderate values keep the friction and clamp paths out of saturation
      r.px = longint'($urandom_range(0, 40000000)) - 20000000;
      r.py = longint'($urandom_range(0, 40000000)) - 20000000;
      r.vx = longint'($urandom_range(0, 2000000)) - 1000000;
      r.vy = longint'($urandom_range(0, 2000000)) - 1000000;
      r.ax = longint'($urandom_range(0, 200000)) - 100000;
      r.ay = longint'($urandom_range(0, 200000)) - 100000;
      r.ix = $urandom_range(0, 3) == 0 ? longint'($urandom_range(0, 200000)) - 100000 : 0;
      r.iy = $urandom_range(0, 3) == 0 ? longint'($urandom_range(0, 200000)) - 100000 : 0;
      r.fx = longint'($urandom_range(0, 2000000)) - 1000000;
      r.fy = longint'($urandom_range(0, 2000000)) - 1000000;
      if ($urandom_range(0, 4) == 0) begin
        r.vx = longint'($urandom_range(0, 1200)) - 600;
        r.vy = longint'($urandom_range(0, 1200)) - 600;
      end
    end else begin
      r.px = rand_s32(); r.py = rand_s32(); r.vx = rand_s32(); r.vy = rand_s32();
      r.ax = rand_s32(); r.ay = rand_s32(); r.ix = rand_s32(); r.iy = rand_s32();
      r.fx = rand_s32(); r.fy = rand_s32();
    end
    return r;
  endfunction

  task automatic send_random(int count);
    repeat (count) send_body(rand_body($urandom_range(0, 3) != 0));
  endtask

  task automatic test_directed_extremes();
    body_req_t r;
    longint edges[4] = '{MAX32, MIN32, 0, -1};
    for (int i = 0; i < 4; i++) begin
      r.tag = i[0] ? 16'hffff : 16'h0000;
      r.px = edges[i]; r.py = edges[3 - i]; r.vx = edges[i]; r.vy = edges[(i + 1) % 4];
      r.ax = edges[(i + 2) % 4]; r.ay = edges[i]; r.ix = edges[3 - i]; r.iy = edges[i];
      r.fx = edges[(i + 1) % 4]; r.fy = edges[(i + 3) % 4];
      r.grounded = i[1];
      send_body(r);
    end
    // below the static limit and exactly at it while grounded, then a fast body grounded and airborne
    r = '{tag: 16'h1234, px: 100, py: -100, vx: 654, vy: 0, ax: 0, ay: 0,
          ix: 0, iy: 0, fx: 0, fy: 0, grounded: 1'b1};
    send_body(r);
    r.vx = 463; r.vy = 463;
    send_body(r);
    r.vx = 655; r.vy = 0;
    send_body(r);
    r.vx = -5000000; r.vy = 3000000;
    send_body(r);
    r.grounded = 1'b0;
    send_body(r);
  endtask

  task automatic test_material(longint g, longint dt, longint m, longint im, longint gs,
                               longint mu, longint damp, longint vmax, int count);
    drain();
    write_reg(rb2d_pkg::REG_GRAVITY, g);
    write_reg(rb2d_pkg::REG_TIME_STEP, dt);
    write_reg(rb2d_pkg::REG_BODY_MASS, m);
    write_reg(rb2d_pkg::REG_INV_MASS, im);
    write_reg(rb2d_pkg::REG_GRAV_SCALE, gs);
    write_reg(rb2d_pkg::REG_KIN_FRICTION, mu);
    write_reg(rb2d_pkg::REG_LIN_DAMPING, damp);
    write_reg(rb2d_pkg::REG_MAX_SPEED, vmax);
    if (count < 30) test_directed_extremes();
    send_random(count);
  endtask

  task automatic test_backpressure_pause();
    send_random(40);
    // hold off until the pipeline has emptied
    in_tvalid <= 1'b0;
    while (expected_bodies.size() != 0) @(posedge clk);
    send_random(40);
    stall_free = 1'b1;
    send_random(150);
    stall_free = 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    body_state_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_bodies.size() == 0) begin
        $error("unexpected result, tag %h", out_tdata[15:0]);
        failures++;
      end else begin
        e = expected_bodies.pop_front();
        if (out_tdata[15:0] !== e.tag) begin
          $error("out_tag expected %h actual %h", e.tag, out_tdata[15:0]);
          failures++;
        end
        if (out_tdata[47:16] !== e.px[31:0]) begin
          $error("new_pos_x expected %0d actual %0d", e.px, $signed(out_tdata[47:16]));
          failures++;
        end
        if (out_tdata[79:48] !== e.py[31:0]) begin
          $error("new_pos_y expected %0d actual %0d", e.py, $signed(out_tdata[79:48]));
          failures++;
        end
        if (out_tdata[111:80] !== e.vx[31:0]) begin
          $error("new_vel_x expected %0d actual %0d", e.vx, $signed(out_tdata[111:80]));
          failures++;
        end
        if (out_tdata[143:112] !== e.vy[31:0]) begin
          $error("new_vel_y expected %0d actual %0d", e.vy, $signed(out_tdata[143:112]));
          failures++;
        end
      end
    end
  end

  // receiver stalls, mostly short with an occasional long hold
  always @(posedge clk) begin
    if (!rst_n || stall_free) begin
      out_tready <= 1'b1;
      hold_cnt = 0;
    end else if (hold_cnt > 0) begin
      out_tready <= 1'b0;
      hold_cnt--;
    end else if ($urandom_range(0, 99) < 2) begin
      out_tready <= 1'b0;
      hold_cnt = $urandom_range(4, 30);
    end else begin
      out_tready <= ($urandom_range(0, 99) < 76);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("rigid_body_2d_step_top test failed");
      $finish;
    end
  end

  initial begin
    failures = 0;
    cycle_count = 0;
    stall_free = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = rb2d_pkg::REG_GRAVITY;
    cfg_wdata = '0;
    exp_gravity = 0; m_dt = 1092; m_mass = 65536; m_inv_mass = 65536;
    m_gscale = 65536; m_mu = 0; m_damping = 0; m_max_speed = MAX32;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults first
    test_directed_extremes();
    send_random(100);
    test_material(-642252, 1092, 65536, 65536, 65536, 19661, 655, 3276800, 8);
    test_material(642252, 65536, 131072, 32768, -65536, 32768, 3277, 655360, 250);
    test_material(-642252, 1092, 65536, 0, 65536, 65536, 0, MAX32, 120);
    test_material(MIN32, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, MIN32, 32'h7fffffff,
                  65536, 0, 100);
    test_material(MAX32, 0, 0, 1, MAX32, 0, 131071, 1, 100);
    test_material(-642252, 2185, 98304, 43691, 32768, 13107, 1311, 1966080, 450);
    test_backpressure_pause();

    drain();
    if (failures == 0) begin
      $display("rigid_body_2d_step_top test passed");
    end else begin
      $display("rigid_body_2d_step_top test failed");
    end
    $finish;
  end
endmodule
